// File: design/pipt_pkg.sv
// shared constants and types for the point-in-polygon test block
`timescale 1ns / 1ps
`default_nettype none

package pipt_pkg;

    // widths fixed by the item and register formats
    localparam int INDEX_BITS    = 4;
    localparam int FIELD_BITS    = 32;
    localparam int COUNT_BITS    = 5;
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    // item operation codes
    typedef enum logic
    {
        OP_LOAD = 1'b0,
        OP_TEST = 1'b1
    } op_t;

    // register map
    localparam logic [APB_ADDR_BITS-1:0] ADDR_VERTEX_COUNT = 3'd0;

endpackage

`default_nettype wire

// File: design/pipt_ifs.sv
// valid/ready channel interfaces for input items and result items
`timescale 1ns / 1ps
`default_nettype none

interface pipt_item_if;
    import pipt_pkg::*;

    logic                         valid;
    logic                         ready;
    logic                         op;
    logic [INDEX_BITS-1:0]        vertex_index;
    logic signed [FIELD_BITS-1:0] coord_x;
    logic signed [FIELD_BITS-1:0] coord_y;

    modport source (output valid, output op, output vertex_index, output coord_x,
                    output coord_y, input ready);
    modport sink (input valid, input op, input vertex_index, input coord_x,
                  input coord_y, output ready);
endinterface

interface pipt_result_if;
    logic valid;
    logic ready;
    logic inside_res;

    modport source (output valid, output inside_res, input ready);
    modport sink (input valid, input inside_res, output ready);
endinterface

`default_nettype wire

// File: design/point_in_polygon_test_top.sv
// crossing-number point-in-polygon test, one edge per pipeline slot
`timescale 1ns / 1ps
`default_nettype none

// every slot is three register stages (diff, multiply, compare); each beat passes the slots in order
// throughput: one item per cycle, held while the result side stalls
// load beats travel the same pipe and update only the vertex copy of the slot matching their index, no result
// a stall at the result side freezes the whole pipe through one global enable
// reset clears vertex_count and all stage valids; vertex copies hold garbage until loaded
module point_in_polygon_test_top #(
    parameter int MAX_VERTICES = 16,
    parameter int COORD_WIDTH  = 32
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [pipt_pkg::APB_ADDR_BITS-1:0] paddr,
    input  wire logic [pipt_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic      [pipt_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                                   pready,
    // item channels
    pipt_item_if.sink                              item_in,
    pipt_result_if.source                          result_out
);
    import pipt_pkg::*;

    localparam int W  = COORD_WIDTH;      // stored coordinate width
    localparam int DW = COORD_WIDTH + 1;  // coordinate difference width
    localparam int PW = 2 * DW;           // cross product width
    localparam int NS = MAX_VERTICES + 1; // edge slots plus the closing slot

    // one item as it moves through the pipe
    typedef struct packed {
        op_t                   op;
        logic [INDEX_BITS-1:0] idx;
        logic signed [W-1:0]   px;
        logic signed [W-1:0]   py;
        logic signed [W-1:0]   prev_x;  // vertex of the previous slot
        logic signed [W-1:0]   prev_y;
        logic signed [W-1:0]   first_x; // vertex 0
        logic signed [W-1:0]   first_y;
        logic signed [W-1:0]   last_x;  // vertex count-1, or vertex MAX_VERTICES-1 when count exceeds MAX_VERTICES
        logic signed [W-1:0]   last_y;
        logic                  parity;
    } item_t;

    logic [COUNT_BITS-1:0] count_reg;
    logic                  en;

    item_t in_item;          // input beat as it enters slot 0
    item_t ent [NS+1];       // slot inputs; ent[NS] is the result register
    logic  ent_v [NS+1];
    logic [NS-1:0] c_valid;  // last-stage valid of every slot
    logic [NS-1:0] span_bad; // crossing flagged on an edge with no y span

    // ------------------------------------------------------------------
    // configuration register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (psel && penable && pwrite && paddr == ADDR_VERTEX_COUNT)
        begin
            count_reg <= pwdata[COUNT_BITS-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (psel && paddr == ADDR_VERTEX_COUNT)
        begin
            prdata = APB_DATA_BITS'(count_reg);
        end
    end

    assign pready = 1'b1;

    // ------------------------------------------------------------------
    // handshake: the pipe advances whenever the result register can move
    // ------------------------------------------------------------------
    assign en               = !result_out.valid || result_out.ready;
    assign item_in.ready    = en;
    assign result_out.valid = ent_v[NS] && (ent[NS].op == OP_TEST);
    assign result_out.inside_res = ent[NS].parity;

    // input beat enters slot 0; coordinates keep their low W bits, signed
    assign ent_v[0] = item_in.valid;
    always_comb
    begin
        in_item        = '0;
        in_item.op     = op_t'(item_in.op);
        in_item.idx    = item_in.vertex_index;
        in_item.px     = item_in.coord_x[W-1:0];
        in_item.py     = item_in.coord_y[W-1:0];
        in_item.parity = 1'b0;
    end

    assign ent[0] = in_item;

    // ------------------------------------------------------------------
    // slots: slot s < MAX_VERTICES handles the edge from vertex s to s-1,
    // the last slot handles the closing edge from vertex 0 to vertex count-1
    // ------------------------------------------------------------------
    for (genvar s = 0; s < NS; s++)
    begin : g_slot
        logic signed [W-1:0]  xi;
        logic signed [W-1:0]  yi;
        logic signed [W-1:0]  xj;
        logic signed [W-1:0]  yj;
        logic                 active;
        logic                 last_sel;
        logic                 straddle;
        item_t                a_next;
        logic signed [DW-1:0] da_next;
        logic signed [DW-1:0] db_next;
        logic signed [DW-1:0] dc_next;
        logic signed [DW-1:0] dd_next;

        logic                 a_v_reg;
        item_t                a_item_reg;
        logic signed [DW-1:0] a_da_reg;
        logic signed [DW-1:0] a_db_reg;
        logic signed [DW-1:0] a_dc_reg;
        logic signed [DW-1:0] a_dd_reg;
        logic                 a_flag_reg;

        logic                 b_v_reg;
        item_t                b_item_reg;
        logic signed [PW-1:0] b_p1_reg;
        logic signed [PW-1:0] b_p2_reg;
        logic                 b_dneg_reg;
        logic                 b_flag_reg;
        logic                 cross_hit;
        item_t                c_next;

        logic                 c_v_reg;
        item_t                c_item_reg;

        if (s < MAX_VERTICES)
        begin : g_edge
            logic signed [W-1:0] vx_reg;
            logic signed [W-1:0] vy_reg;

            // this slot's copy of vertex s, written as a load beat passes
            always_ff @(posedge clk)
            begin
                if (en && ent_v[s] && ent[s].op == OP_LOAD && int'(ent[s].idx) == s)
                begin
                    vx_reg <= ent[s].px;
                    vy_reg <= ent[s].py;
                end
            end

            assign xi       = vx_reg;
            assign yi       = vy_reg;
            assign xj       = ent[s].prev_x;
            assign yj       = ent[s].prev_y;
            assign active   = (s >= 1) && (s < int'(count_reg));
            assign last_sel = (s + 1 == int'(count_reg))
                              || ((s == MAX_VERTICES - 1) && (int'(count_reg) > MAX_VERTICES));
        end
        else
        begin : g_close
            assign xi       = ent[s].first_x;
            assign yi       = ent[s].first_y;
            assign xj       = ent[s].last_x;
            assign yj       = ent[s].last_y;
            assign active   = (count_reg != '0);
            assign last_sel = 1'b0;
        end

        // stage a: spans and straddle test, carry vertices forward
        always_comb
        begin
            a_next        = ent[s];
            a_next.prev_x = xi;
            a_next.prev_y = yi;
            if (s == 0)
            begin
                a_next.first_x = xi;
                a_next.first_y = yi;
            end
            if (last_sel)
            begin
                a_next.last_x = xi;
                a_next.last_y = yi;
            end
            da_next  = DW'(ent[s].px) - DW'(xi);
            db_next  = DW'(xj) - DW'(xi);
            dc_next  = DW'(ent[s].py) - DW'(yi);
            dd_next  = DW'(yj) - DW'(yi);
            straddle = (yi > ent[s].py) != (yj > ent[s].py);
        end

        // stage c input: exact compare of (px-xi)*(yj-yi) with (xj-xi)*(py-yi)
        always_comb
        begin
            cross_hit     = b_dneg_reg ? (b_p1_reg > b_p2_reg) : (b_p1_reg < b_p2_reg);
            c_next        = b_item_reg;
            c_next.parity = b_item_reg.parity ^ (b_flag_reg && cross_hit);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                a_v_reg <= 1'b0;
                b_v_reg <= 1'b0;
                c_v_reg <= 1'b0;
            end
            else if (en)
            begin
                a_v_reg <= ent_v[s];
                b_v_reg <= a_v_reg;
                c_v_reg <= b_v_reg;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                a_item_reg <= a_next;
                a_da_reg   <= da_next;
                a_db_reg   <= db_next;
                a_dc_reg   <= dc_next;
                a_dd_reg   <= dd_next;
                a_flag_reg <= (ent[s].op == OP_TEST) && active && straddle;

                b_item_reg <= a_item_reg;
                b_p1_reg   <= PW'(a_da_reg) * PW'(a_dd_reg);
                b_p2_reg   <= PW'(a_db_reg) * PW'(a_dc_reg);
                b_dneg_reg <= a_dd_reg[DW-1];
                b_flag_reg <= a_flag_reg;

                c_item_reg <= c_next;
            end
        end

        assign ent[s+1]    = c_item_reg;
        assign ent_v[s+1]  = c_v_reg;
        assign c_valid[s]  = c_v_reg;
        assign span_bad[s] = a_v_reg && a_flag_reg && (a_dd_reg == '0);
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------

    // a straddling edge always has a nonzero y span, so the sign fix is sound
    assert property (@(posedge clk) disable iff (!rst_n) span_bad == '0)
        else $error("crossing flagged on an edge with zero y span");

    // a stalled pipe keeps every slot's last-stage valid in place
    assert property (@(posedge clk) disable iff (!rst_n) !en |=> $stable(c_valid))
        else $error("pipe moved while stalled");

    // with no result waiting the block takes input
    assert property (@(posedge clk) disable iff (!rst_n) !result_out.valid |-> item_in.ready)
        else $error("input blocked while result register is free");

endmodule

`default_nettype wire
